### rtl/ccl_pkg.sv
// Package for the coulomb counter with landmark resets: field widths,
// register map, reset values, landmark codes and the configuration struct.
// No dependencies.
package ccl_pkg;

  // Field widths
  localparam int VOLT_W   = 17;
  localparam int CUR_W    = 16;
  localparam int MS_W     = 16;
  localparam int CHARGE_W = 38;
  localparam int PCT_W    = 7;
  localparam int LM_W     = 2;
  localparam int CAP_W    = 16;
  localparam int REQ_W    = 8;

  // Product of current and time, plus one bit for the zero-extended time
  localparam int PROD_W   = CUR_W + MS_W + 1;
  // Signed sum of charge and product
  localparam int SUM_W    = CHARGE_W + 2;

  // Microcoulombs per milliamp hour
  localparam int UC_W = 22;
  localparam logic [UC_W-1:0] UC_PER_MAH = UC_W'(3600000);

  // Percent divider: 7 quotient bits cover 0..100
  localparam int QUOT_W = PCT_W;
  localparam int DIV_W  = CHARGE_W + QUOT_W;
  localparam int CNT_W  = $clog2(QUOT_W);

  // Register map (byte address = 4 * index)
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_FULL_TH  = 2'd1;
  localparam logic [1:0] REG_EMPTY_TH = 2'd2;
  localparam logic [1:0] REG_SAMPLES  = 2'd3;

  localparam logic [CAP_W-1:0]  RST_CAPACITY = CAP_W'(2000);
  localparam logic [VOLT_W-1:0] RST_FULL_TH  = VOLT_W'(4150);
  localparam logic [VOLT_W-1:0] RST_EMPTY_TH = VOLT_W'(3300);
  localparam logic [REQ_W-1:0]  RST_SAMPLES  = REQ_W'(10);

  // Landmark codes
  localparam logic [LM_W-1:0] LM_NONE  = 2'd0;
  localparam logic [LM_W-1:0] LM_FULL  = 2'd1;
  localparam logic [LM_W-1:0] LM_EMPTY = 2'd2;

  typedef struct packed {
    logic [CAP_W-1:0]  capacity_mah;
    logic [VOLT_W-1:0] full_threshold_mv;
    logic [VOLT_W-1:0] empty_threshold_mv;
    logic [REQ_W-1:0]  samples_required;
  } cfg_t;

endpackage

### rtl/ccl_if.sv
// Channel interfaces of the coulomb counter: sample word in, result word out.
// Depends on ccl_pkg for field widths.
interface ccl_sample_if;
  logic                        valid;
  logic                        ready;
  logic [ccl_pkg::VOLT_W-1:0]  bus_voltage_mv;
  logic signed [ccl_pkg::CUR_W-1:0] current_ma;
  logic [ccl_pkg::MS_W-1:0]    elapsed_ms;

  modport source (output valid, bus_voltage_mv, current_ma, elapsed_ms, input ready);
  modport sink   (input valid, bus_voltage_mv, current_ma, elapsed_ms, output ready);
endinterface

interface ccl_result_if;
  logic                          valid;
  logic                          ready;
  logic [ccl_pkg::CHARGE_W-1:0]  consumed_charge_uc;
  logic [ccl_pkg::PCT_W-1:0]     percent_left;
  logic [ccl_pkg::LM_W-1:0]      landmark_reset;

  modport source (output valid, consumed_charge_uc, percent_left, landmark_reset,
                  input ready);
  modport sink   (input valid, consumed_charge_uc, percent_left, landmark_reset,
                  output ready);
endinterface

### rtl/ccl_cfg.sv
// APB-style configuration registers of the coulomb counter.
// Depends on ccl_pkg (register map, reset values, cfg_t).
module ccl_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccl_pkg::ADDR_W-1:0] paddr,
  input  logic [ccl_pkg::DATA_W-1:0] pwdata,
  output logic [ccl_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ccl_pkg::cfg_t              cfg
);
  import ccl_pkg::*;

  logic [1:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite & pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity_mah       <= RST_CAPACITY;
      cfg.full_threshold_mv  <= RST_FULL_TH;
      cfg.empty_threshold_mv <= RST_EMPTY_TH;
      cfg.samples_required   <= RST_SAMPLES;
    end else if (wr_en) begin
      case (idx)
        REG_CAPACITY: cfg.capacity_mah       <= pwdata[CAP_W-1:0];
        REG_FULL_TH:  cfg.full_threshold_mv  <= pwdata[VOLT_W-1:0];
        REG_EMPTY_TH: cfg.empty_threshold_mv <= pwdata[VOLT_W-1:0];
        REG_SAMPLES:  cfg.samples_required   <= pwdata[REQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_CAPACITY: prdata = DATA_W'(cfg.capacity_mah);
      REG_FULL_TH:  prdata = DATA_W'(cfg.full_threshold_mv);
      REG_EMPTY_TH: prdata = DATA_W'(cfg.empty_threshold_mv);
      REG_SAMPLES:  prdata = DATA_W'(cfg.samples_required);
      default:      prdata = '0;
    endcase
  end

endmodule

### rtl/ccl_div.sv
// Iterative shift-subtract unit for the percent figure:
// quot = floor(rem * 100 / divisor), one quotient bit per cycle. Depends on ccl_pkg.
module ccl_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ccl_pkg::CHARGE_W-1:0] rem,
  input  logic [ccl_pkg::CHARGE_W-1:0] divisor,
  output logic                         busy,
  output logic                         done,
  output logic [ccl_pkg::QUOT_W-1:0]   quot
);
  import ccl_pkg::*;

  logic [DIV_W-1:0] dividend;
  logic [DIV_W-1:0] dsh;
  logic [CNT_W-1:0] cnt;
  logic             fits;

  // One compare and subtract per cycle
  assign fits = (dividend >= dsh);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: dividend = rem * 100 as rem*64 + rem*32 + rem*4
  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= {1'b0, rem, 6'b0} + {2'b0, rem, 5'b0} + {5'b0, rem, 2'b0};
      dsh      <= {1'b0, divisor, 6'b0};
      quot     <= '0;
    end else if (busy) begin
      if (fits) begin
        dividend <= dividend - dsh;
      end
      quot <= {quot[QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("divider went busy without a start");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("divider done without a finished run");
`endif

endmodule

### rtl/coulomb_counter_landmark_reset_unit.sv
// Top level of the coulomb counter fuel gauge with voltage landmark resets.
// Depends on ccl_pkg, ccl_if (ccl_sample_if, ccl_result_if), ccl_cfg, ccl_div.
//
//   channel   dir  handshake       word
//   smp       in   valid/ready     bus_voltage_mv, current_ma, elapsed_ms
//   res       out  valid/ready     consumed_charge_uc, percent_left, landmark_reset
//   apb       in   psel/penable    capacity, thresholds, samples required
//
// An accepted sample passes the capacity, multiply, accumulate and percent
// steps, then the shift-subtract divider when the charge sits below a nonzero
// capacity, then the done step. The sample side is ready only while the
// sequencer is idle. A finished result waits in the output register and the
// next sample is accepted meanwhile; a new result loads only once the old one
// is taken. Reset (rst, synchronous) clears the charge, both run counts and
// the registers to their defaults; no clearing pass is needed.
module coulomb_counter_landmark_reset_unit (
  input  logic                       clk,
  input  logic                       rst,
  ccl_sample_if.sink                 smp,
  ccl_result_if.source               res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccl_pkg::ADDR_W-1:0] paddr,
  input  logic [ccl_pkg::DATA_W-1:0] pwdata,
  output logic [ccl_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import ccl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CAP  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_PCT  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  cfg_t cfg;

  logic [2:0]               state;
  logic [VOLT_W-1:0]        volt;
  logic signed [CUR_W-1:0]  cur;
  logic [MS_W-1:0]          ms;
  logic [CHARGE_W-1:0]      cap_uc;
  logic signed [PROD_W-1:0] prod;
  logic [CHARGE_W-1:0]      charge;
  logic [REQ_W-1:0]         full_cnt;
  logic [REQ_W-1:0]         empty_cnt;
  logic [LM_W-1:0]          lm;
  logic [PCT_W-1:0]         pct;

  logic                     out_valid;
  logic [CHARGE_W-1:0]      out_charge;
  logic [PCT_W-1:0]         out_pct;
  logic [LM_W-1:0]          out_lm;

  logic [CHARGE_W-1:0]      cap_prod;
  logic signed [SUM_W-1:0]  sum;
  logic [CHARGE_W-1:0]      clamped;
  logic [CHARGE_W-1:0]      charge_next;
  logic [REQ_W-1:0]         full_cnt_next;
  logic [REQ_W-1:0]         empty_cnt_next;
  logic [LM_W-1:0]          lm_next;

  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [QUOT_W-1:0]        div_quot;
  logic                     out_free;

  ccl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccl_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .rem     (cap_uc - charge),
    .divisor (cap_uc),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (div_quot)
  );

  assign smp.ready              = (state == S_IDLE);
  assign res.valid              = out_valid;
  assign res.consumed_charge_uc = out_charge;
  assign res.percent_left       = out_pct;
  assign res.landmark_reset     = out_lm;

  assign out_free  = !out_valid || res.ready;
  assign div_start = (state == S_PCT) && (cap_uc != '0) && (charge < cap_uc);

  // Capacity in uC
  assign cap_prod = CHARGE_W'(cfg.capacity_mah) * CHARGE_W'(UC_PER_MAH);

  // Integrate, clamp to [0, cap]
  always_comb begin
    sum = $signed({2'b00, charge}) + SUM_W'(prod);
    if (sum[SUM_W-1]) begin
      clamped = '0;
    end else if (sum[SUM_W-2:0] > {1'b0, cap_uc}) begin
      clamped = cap_uc;
    end else begin
      clamped = sum[CHARGE_W-1:0];
    end
  end

  // Voltage landmarks
  always_comb begin
    charge_next    = clamped;
    full_cnt_next  = full_cnt;
    empty_cnt_next = empty_cnt;
    lm_next        = LM_NONE;
    if (volt > cfg.full_threshold_mv) begin
      if (full_cnt < cfg.samples_required) begin
        full_cnt_next = full_cnt + 1'b1;
      end
      empty_cnt_next = '0;
      if ((full_cnt_next >= cfg.samples_required) && (clamped != '0)) begin
        charge_next = '0;
        lm_next     = LM_FULL;
      end
    end else if (volt < cfg.empty_threshold_mv) begin
      if (empty_cnt < cfg.samples_required) begin
        empty_cnt_next = empty_cnt + 1'b1;
      end
      full_cnt_next = '0;
      if ((empty_cnt_next >= cfg.samples_required) && (clamped != cap_uc)) begin
        charge_next = cap_uc;
        lm_next     = LM_EMPTY;
      end
    end else begin
      full_cnt_next  = '0;
      empty_cnt_next = '0;
    end
  end

  // Sequencer and gauge state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      charge    <= '0;
      full_cnt  <= '0;
      empty_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      // Output word: load from the done step, drop once taken
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (smp.valid) begin
            state <= S_CAP;
          end
        end
        S_CAP: state <= S_MUL;
        S_MUL: state <= S_ACC;
        S_ACC: begin
          charge    <= charge_next;
          full_cnt  <= full_cnt_next;
          empty_cnt <= empty_cnt_next;
          state     <= S_PCT;
        end
        S_PCT: state <= div_start ? S_DIV : S_DONE;
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (smp.valid) begin
          volt <= smp.bus_voltage_mv;
          cur  <= smp.current_ma;
          ms   <= smp.elapsed_ms;
        end
      end
      S_CAP: cap_uc <= cap_prod;
      S_MUL: prod <= cur * $signed({1'b0, ms});
      S_ACC: lm <= lm_next;
      S_PCT: pct <= '0;
      S_DIV: begin
        if (div_done) begin
          pct <= div_quot;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_charge <= charge;
          out_pct    <= pct;
          out_lm     <= lm;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_full_means_empty_charge: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_lm == LM_FULL) |-> (out_charge == '0))
    else $error("full landmark reported with nonzero charge");
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_pct <= PCT_W'(100)))
    else $error("percent above 100");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result loaded outside the done step");
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy)
    else $error("divider busy while sequencer idle");
`endif

endmodule

### tb/coulomb_counter_landmark_reset_unit_test.sv
// Self-checking testbench for the coulomb counter fuel gauge with landmark resets.
// Drives sample words and APB register writes, predicts every result word in place.
// Depends on ccl_pkg, ccl_if and coulomb_counter_landmark_reset_unit.
module coulomb_counter_landmark_reset_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ccl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int VOLT_MAX       = 85000;

  typedef struct packed {
    logic [CHARGE_W-1:0] charge;
    logic [PCT_W-1:0]    pct;
    logic [LM_W-1:0]     lm;
  } gauge_word_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ccl_sample_if smp();
  ccl_result_if res();

  coulomb_counter_landmark_reset_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .smp     (smp),
    .res     (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Gauge copy: registers and state
  logic [CAP_W-1:0]    gauge_capacity;
  logic [VOLT_W-1:0]   gauge_full_th;
  logic [VOLT_W-1:0]   gauge_empty_th;
  logic [REQ_W-1:0]    gauge_samples;
  logic [CHARGE_W-1:0] gauge_charge;
  logic [REQ_W-1:0]    gauge_full_run;
  logic [REQ_W-1:0]    gauge_empty_run;

  gauge_word_t gauge_words_due[$];
  int          mismatches;
  int          quiet_cycles;
  bit          idle_en;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_gauge();
    gauge_capacity  = RST_CAPACITY;
    gauge_full_th   = RST_FULL_TH;
    gauge_empty_th  = RST_EMPTY_TH;
    gauge_samples   = RST_SAMPLES;
    gauge_charge    = '0;
    gauge_full_run  = '0;
    gauge_empty_run = '0;
  endfunction

  // Integrate, clamp, apply landmarks, then work out percent left
  function automatic gauge_word_t predict_gauge(input logic [VOLT_W-1:0] volt,
                                                input logic signed [CUR_W-1:0] cur,
                                                input logic [MS_W-1:0] ms);
    longint      cap;
    longint      q;
    longint      pct;
    gauge_word_t w;
    cap  = longint'(gauge_capacity) * longint'(UC_PER_MAH);
    q    = longint'(gauge_charge) + longint'(cur) * longint'(ms);
    w.lm = LM_NONE;
    if (q < 0) q = 0;
    if (q > cap) q = cap;
    if (volt > gauge_full_th) begin
      if (gauge_full_run < gauge_samples) gauge_full_run = gauge_full_run + 1'b1;
      gauge_empty_run = '0;
      if (gauge_full_run >= gauge_samples && q != 0) begin
        q    = 0;
        w.lm = LM_FULL;
      end
    end else if (volt < gauge_empty_th) begin
      if (gauge_empty_run < gauge_samples) gauge_empty_run = gauge_empty_run + 1'b1;
      gauge_full_run = '0;
      if (gauge_empty_run >= gauge_samples && q != cap) begin
        q    = cap;
        w.lm = LM_EMPTY;
      end
    end else begin
      gauge_full_run  = '0;
      gauge_empty_run = '0;
    end
    gauge_charge = q[CHARGE_W-1:0];
    pct = 0;
    if (cap > 0 && q < cap) begin
      pct = ((cap - q) * 100) / cap;
      if (pct > 100) pct = 100;
    end
    w.charge = gauge_charge;
    w.pct    = pct[PCT_W-1:0];
    return w;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0d, actual %0d", what, want, got);
  endfunction

  // Result checker, sample monitor and watchdog
  always @(posedge clk) begin
    gauge_word_t want;
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (gauge_words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: charge %0d percent %0d landmark %0d",
                     res.consumed_charge_uc, res.percent_left, res.landmark_reset);
        end else begin
          want = gauge_words_due.pop_front();
          if (res.consumed_charge_uc !== want.charge)
            flag_mismatch("consumed_charge_uc", 64'(want.charge),
                          64'(res.consumed_charge_uc));
          if (res.percent_left !== want.pct)
            flag_mismatch("percent_left", 64'(want.pct), 64'(res.percent_left));
          if (res.landmark_reset !== want.lm)
            flag_mismatch("landmark_reset", 64'(want.lm), 64'(res.landmark_reset));
        end
      end
      if (smp.valid && smp.ready)
        gauge_words_due.push_back(predict_gauge(smp.bus_voltage_mv, smp.current_ma,
                                                smp.elapsed_ms));
    end
    if ((smp.valid && smp.ready) || (res.valid && res.ready) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side back-pressure in random bursts
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 4) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      res.ready <= 1'b1;
    end
  end

  // Send one sample word, with an optional gap ahead of it
  task automatic send_sample(input int volt, input int cur, input int ms);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    smp.valid          <= 1'b1;
    smp.bus_voltage_mv <= VOLT_W'(volt);
    smp.current_ma     <= CUR_W'(cur);
    smp.elapsed_ms     <= MS_W'(ms);
    do @(posedge clk); while (!smp.ready);
  endtask

  // Hold off samples until every predicted word has come back
  task automatic settle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (gauge_words_due.size() != 0) @(posedge clk);
  endtask

  // APB write, then read back the same register
  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    logic [DATA_W-1:0] want;
    logic [DATA_W-1:0] got;
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_CAPACITY: begin
        gauge_capacity = value[CAP_W-1:0];
        want = DATA_W'(gauge_capacity);
      end
      REG_FULL_TH: begin
        gauge_full_th = value[VOLT_W-1:0];
        want = DATA_W'(gauge_full_th);
      end
      REG_EMPTY_TH: begin
        gauge_empty_th = value[VOLT_W-1:0];
        want = DATA_W'(gauge_empty_th);
      end
      default: begin
        gauge_samples = value[REQ_W-1:0];
        want = DATA_W'(gauge_samples);
      end
    endcase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) flag_mismatch("register readback", 64'(want), 64'(got));
  endtask

  task automatic set_gauge(input int unsigned cap, input int unsigned full_th,
                           input int unsigned empty_th, input int unsigned req);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_FULL_TH, full_th);
    write_reg(REG_EMPTY_TH, empty_th);
    write_reg(REG_SAMPLES, req);
  endtask

  // Voltage for a region: 0 above full, 1 below empty, 2 between, else anywhere
  function automatic int pick_voltage(input int region);
    int lo;
    int hi;
    lo = 0;
    hi = VOLT_MAX;
    case (region)
      0: if (gauge_full_th < VOLT_MAX) lo = int'(gauge_full_th) + 1;
      1: if (gauge_empty_th > 0) hi = int'(gauge_empty_th) - 1;
      2: if (gauge_empty_th <= gauge_full_th) begin
        lo = int'(gauge_empty_th);
        hi = int'(gauge_full_th);
      end
      default: ;
    endcase
    if (hi > VOLT_MAX) hi = VOLT_MAX;
    return int'($urandom_range(lo, hi));
  endfunction

  function automatic int pick_current();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 4000)) - 2000;
      1: return int'($urandom_range(0, 65535)) - 32768;
      2: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return int'($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  // Runs of samples in one voltage region, up to three samples longer than a landmark needs
  task automatic run_random(input int count);
    int region;
    int run_left;
    int sel;
    int ms;
    run_left = 0;
    region   = 0;
    for (int k = 0; k < count; k++) begin
      if (run_left == 0) begin
        sel      = $urandom_range(0, 9);
        region   = (sel < 4) ? 0 : (sel < 8) ? 1 : (sel == 8) ? 2 : 3;
        run_left = $urandom_range(1, int'(gauge_samples) + 3);
      end
      run_left--;
      ms = $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom_range(0, 65535);
      send_sample(pick_voltage(region), pick_current(), ms);
      if (k == count / 2) settle();
    end
  endtask

  // Field extremes at reset settings, thresholds hit exactly
  task automatic test_sample_extremes();
    send_sample(3700, 32767, 65535);
    send_sample(3700, 32767, 65535);
    send_sample(3700, -32768, 65535);
    send_sample(3700, -32768, 65535);
    send_sample(0, 0, 0);
    send_sample(VOLT_MAX, 0, 0);
    send_sample(3300, 1, 1);
    send_sample(4150, 1, 1);
  endtask

  // Both landmarks firing, and again with the charge already there
  task automatic test_landmarks();
    set_gauge(1, 4150, 3300, 1);
    send_sample(3700, 32767, 65535);
    send_sample(VOLT_MAX, 0, 0);
    send_sample(VOLT_MAX, 0, 0);
    send_sample(0, 0, 0);
    send_sample(0, 0, 0);
    send_sample(3700, -1, 1);
  endtask

  // Zero run length, zero and largest capacity, capacity lowered under a charge
  task automatic test_degenerate_config();
    set_gauge(0, 4150, 3300, 0);
    send_sample(3700, 100, 100);
    send_sample(VOLT_MAX, 0, 0);
    send_sample(0, 0, 0);
    write_reg(REG_CAPACITY, 65535);
    send_sample(0, 0, 0);
    send_sample(VOLT_MAX, 0, 0);
    send_sample(0, 0, 0);
    write_reg(REG_CAPACITY, 2);
    send_sample(3700, 0, 0);
  endtask

  // Thresholds at both ends, and crossed so that full wins
  task automatic test_threshold_extremes();
    set_gauge(2000, 0, 0, 1);
    send_sample(0, 5, 5);
    send_sample(1, 5, 5);
    set_gauge(2000, VOLT_MAX, VOLT_MAX, 1);
    send_sample(VOLT_MAX, 0, 0);
    send_sample(VOLT_MAX - 1, 0, 0);
    set_gauge(2000, 3000, 5000, 1);
    send_sample(4000, 0, 0);
  endtask

  task automatic test_random_reset_settings();
    set_gauge(RST_CAPACITY, RST_FULL_TH, RST_EMPTY_TH, RST_SAMPLES);
    run_random(200);
  endtask

  task automatic test_random_small_capacity();
    int unsigned full_th;
    full_th = $urandom_range(3000, 5000);
    set_gauge($urandom_range(1, 50), full_th, $urandom_range(2000, full_th),
              $urandom_range(1, 5));
    run_random(150);
  endtask

  task automatic test_random_wide_config();
    set_gauge(65535, VOLT_MAX, 0, 255);
    run_random(100);
  endtask

  task automatic test_random_instant_landmarks();
    set_gauge($urandom_range(1, 65535), $urandom_range(0, VOLT_MAX),
              $urandom_range(0, VOLT_MAX), 0);
    run_random(100);
  endtask

  // Last part: no gaps and no stalls
  task automatic test_random_back_to_back();
    int unsigned full_th;
    idle_en = 1'b0;
    full_th = $urandom_range(3000, 5000);
    set_gauge($urandom_range(1, 200), full_th, $urandom_range(2000, full_th),
              $urandom_range(1, 4));
    run_random(100);
  endtask

  initial begin
    mismatches   = 0;
    quiet_cycles = 0;
    idle_en      = 1'b1;
    reset_gauge();
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    smp.valid          <= 1'b0;
    smp.bus_voltage_mv <= '0;
    smp.current_ma     <= '0;
    smp.elapsed_ms     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_sample_extremes();
    test_landmarks();
    test_degenerate_config();
    test_threshold_extremes();
    test_random_reset_settings();
    test_random_small_capacity();
    test_random_wide_config();
    test_random_instant_landmarks();
    test_random_back_to_back();

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && gauge_words_due.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
